// File: rtl/core/ssmmg_pkg.sv
// Shared types and constants for the sorted store with min/max gap reporting.
// No dependencies.
package ssmmg_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] stored_count;
        logic [VALUE_W-1:0] longest_gap;
        logic [VALUE_W-1:0] shortest_gap;
    } result_beat_t;

    typedef struct packed {
        logic               insert;
        logic               gap_load;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// File: rtl/core/ssmmg_cell.sv
// One storage cell of the sorted chain: holds a value and the gap to its left neighbor.
// Depends on ssmmg_pkg.
module ssmmg_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                              clk,
    input  ssmmg_pkg::cell_ctl_t              ctl,
    input  logic [CNT_W-1:0]                  count,
    input  logic [ssmmg_pkg::VALUE_W-1:0]     left_value,
    output logic [ssmmg_pkg::VALUE_W-1:0]     value,
    output logic [ssmmg_pkg::VALUE_W-1:0]     gap
);

    logic [ssmmg_pkg::VALUE_W-1:0] value_reg;
    logic [ssmmg_pkg::VALUE_W-1:0] value_next;
    logic [ssmmg_pkg::VALUE_W-1:0] gap_reg;
    logic [ssmmg_pkg::VALUE_W-1:0] gap_next;
    logic                          occupied;
    logic                          tail;
    logic                          left_le;
    logic                          own_gt;
    logic                          gap_valid;

    always_comb
    begin
        occupied  = 32'(INDEX) < 32'(count);
        tail      = 32'(INDEX) == 32'(count);
        own_gt    = $signed(value_reg) > $signed(ctl.value);
        left_le   = (INDEX == 0) || ($signed(left_value) <= $signed(ctl.value));
        gap_valid = (INDEX != 0) && occupied;
        value_next = value_reg;
        if (ctl.insert && (tail || (occupied && own_gt)))
        begin
            value_next = left_le ? ctl.value : left_value;
        end
        gap_next = gap_reg;
        if (ctl.gap_load)
        begin
            gap_next = gap_valid ? (value_reg - left_value) : '1;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        gap_reg   <= gap_next;
    end

    assign value = value_reg;
    assign gap   = gap_reg;

endmodule

// File: rtl/core/ssmmg_min_tree.sv
// Registered binary minimum tree over the cell gaps; every compare level is registered.
// Depends on ssmmg_pkg.
module ssmmg_min_tree #(
    parameter int LEAVES = 64,
    parameter int LEVELS = 6
) (
    input  logic                                       clk,
    input  logic [LEAVES-1:0][ssmmg_pkg::VALUE_W-1:0]  leaf,
    output logic [ssmmg_pkg::VALUE_W-1:0]              root
);

    localparam int PAD   = 2 ** LEVELS;
    localparam int INNER = PAD - 1;

    logic [ssmmg_pkg::VALUE_W-1:0] leaf_pad [PAD];
    logic [ssmmg_pkg::VALUE_W-1:0] node_reg [INNER];

    genvar k;
    generate
        for (k = 0; k < PAD; k++)
        begin : g_leaf
            if (k < LEAVES)
            begin : g_real
                assign leaf_pad[k] = leaf[k];
            end
            else
            begin : g_fill
                assign leaf_pad[k] = '1;
            end
        end

        for (k = 0; k < INNER; k++)
        begin : g_node
            logic [ssmmg_pkg::VALUE_W-1:0] lhs;
            logic [ssmmg_pkg::VALUE_W-1:0] rhs;
            if (2 * k + 1 >= INNER)
            begin : g_from_leaf
                assign lhs = leaf_pad[2 * k + 1 - INNER];
                assign rhs = leaf_pad[2 * k + 2 - INNER];
            end
            else
            begin : g_from_node
                assign lhs = node_reg[2 * k + 1];
                assign rhs = node_reg[2 * k + 2];
            end
            always_ff @(posedge clk)
            begin
                node_reg[k] <= (rhs < lhs) ? rhs : lhs;
            end
        end
    endgenerate

    assign root = node_reg[0];

endmodule

// File: rtl/core/sorted_store_min_max_gap.sv
// Sorted store of signed numbers reporting the full span (max - min) and shortest neighbor gap.
// Steps: the accept edge inserts, ST_GAP loads the cell gaps, ST_WAIT spans the LEVELS =
// clog2(MAX_ENTRIES) registered min-tree levels, then ST_DONE registers result and strobe.
// Commands are taken only while idle; busy is high until the strobe. Receiver cannot stall.
// Reset clears the count and sets capacity to 64; stored numbers are not cleared.
// Depends on ssmmg_pkg, ssmmg_cell, ssmmg_min_tree.
module sorted_store_min_max_gap #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ssmmg_pkg::cmd_beat_t             cmd,
    output logic                             result_valid,
    output ssmmg_pkg::result_beat_t          result,
    input  logic                             cfg_we,
    input  logic [ssmmg_pkg::CAP_W-1:0]      cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LEVELS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WAIT_W = $clog2(LEVELS) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAP,
        ST_WAIT,
        ST_DONE
    } state_t;

    state_t                            state_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [ssmmg_pkg::CAP_W-1:0]       capacity_reg;
    logic [ssmmg_pkg::VALUE_W-1:0]     min_reg;
    logic [ssmmg_pkg::VALUE_W-1:0]     max_reg;
    logic                              full_reg;
    logic [WAIT_W-1:0]                 wait_reg;
    logic                              result_valid_reg;
    ssmmg_pkg::result_beat_t           result_reg;

    ssmmg_pkg::cell_ctl_t              ctl;
    logic                              accept;
    logic                              full;
    logic [31:0]                       limit;
    logic                              two_or_more;
    logic [31:0]                       count_ext;
    logic [ssmmg_pkg::VALUE_W-1:0]     shortest;
    logic [ssmmg_pkg::VALUE_W-1:0]     cell_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0][ssmmg_pkg::VALUE_W-1:0] cell_gap;

    always_comb
    begin
        accept      = start && (state_reg == ST_IDLE);
        limit       = (32'(capacity_reg) < 32'(MAX_ENTRIES)) ? 32'(capacity_reg)
                                                              : 32'(MAX_ENTRIES);
        full        = 32'(count_reg) >= limit;
        count_ext   = 32'(count_reg);
        two_or_more = count_ext >= 32'd2;
        ctl.insert   = accept && (cmd.mode == ssmmg_pkg::MODE_ADD) && !full;
        ctl.gap_load = state_reg == ST_GAP;
        ctl.value    = cmd.value;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ENTRIES; i++)
        begin : g_cell
            logic [ssmmg_pkg::VALUE_W-1:0] left;
            if (i == 0)
            begin : g_head
                assign left = '0;
            end
            else
            begin : g_link
                assign left = cell_value[i - 1];
            end
            ssmmg_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .count      (count_reg),
                .left_value (left),
                .value      (cell_value[i]),
                .gap        (cell_gap[i])
            );
        end
    endgenerate

    ssmmg_min_tree #(
        .LEAVES (MAX_ENTRIES),
        .LEVELS (LEVELS)
    ) u_min_tree (
        .clk  (clk),
        .leaf (cell_gap),
        .root (shortest)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            capacity_reg     <= ssmmg_pkg::CAPACITY_RESET;
            full_reg         <= 1'b0;
            wait_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        full_reg  <= 1'b0;
                        state_reg <= ST_GAP;
                        if (cmd.mode == ssmmg_pkg::MODE_CLEAR)
                        begin
                            count_reg <= '0;
                        end
                        else if (full)
                        begin
                            full_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (count_reg == '0 || $signed(cmd.value) < $signed(min_reg))
                            begin
                                min_reg <= cmd.value;
                            end
                            if (count_reg == '0 || $signed(cmd.value) >= $signed(max_reg))
                            begin
                                max_reg <= cmd.value;
                            end
                        end
                    end
                end
                ST_GAP:
                begin
                    wait_reg  <= WAIT_W'(LEVELS - 1);
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (wait_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                end
                ST_DONE:
                begin
                    result_valid_reg        <= 1'b1;
                    result_reg.stored_count <= count_ext[ssmmg_pkg::COUNT_W-1:0];
                    if (two_or_more)
                    begin
                        result_reg.status       <= full_reg ? ssmmg_pkg::STATUS_FULL
                                                            : ssmmg_pkg::STATUS_OK;
                        result_reg.longest_gap  <= max_reg - min_reg;
                        result_reg.shortest_gap <= shortest;
                    end
                    else
                    begin
                        result_reg.status       <= full_reg ? ssmmg_pkg::STATUS_FULL
                                                            : ssmmg_pkg::STATUS_SHORT;
                        result_reg.longest_gap  <= '0;
                        result_reg.shortest_gap <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
